FILE: rtl/i2cmra_pkg.sv
package i2cmra_pkg;

    localparam logic [1:0] ACT_QUEUE = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_NACK   = 2'd1;
    localparam logic [1:0] STS_OVERLEN = 2'd2;

    localparam logic REG_PHASE_TICKS = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic       is_read;
        logic [7:0] length;
        logic [7:0] wr_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic       rd_last;
        logic       done_res;
        logic [1:0] status;
    } result_t;

endpackage

FILE: rtl/i2cmra_ctrl.sv
module i2cmra_ctrl #(
    parameter int BUF_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  i2cmra_pkg::item_t  item,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [7:0]         cfg_wdata,
    output i2cmra_pkg::result_t res
);
    import i2cmra_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int FW = $clog2(BUF_DEPTH + 1);
    localparam int CW = (FW > 8) ? FW : 8;

    typedef enum logic [4:0] {
        S_IDLE, S_ST_SDA_HI, S_ST_SCL_HI, S_ST_SDA_LO, S_ST_SCL_LO,
        S_TX_SCL_LO, S_TX_SDA, S_TX_SCL_HI, S_TX_END,
        S_ACK_REL, S_ACK_SCL_HI, S_ACK_SCL_LO,
        S_RX_SCL_LO, S_RX_SCL_HI, S_RX_END,
        S_MA_SDA, S_MA_SCL_HI, S_MA_SCL_LO,
        S_SP_SCL_LO, S_SP_SDA_LO, S_SP_SCL_HI, S_SP_SDA_HI
    } state_t;

    typedef enum logic [1:0] {
        R_ADDR_WR, R_REG, R_DATA, R_ADDR_RD
    } role_t;

    state_t        state_reg, state_next, go_st;
    role_t         role_reg, role_next;
    logic [7:0]    phase_ticks_reg, phase_ticks_next;
    logic [7:0]    ack_timeout_reg, ack_timeout_next;
    logic [7:0]    phase_count_reg, phase_count_next;
    logic [3:0]    bit_count_reg, bit_count_next;
    logic [7:0]    shift_reg_reg, shift_reg_next;
    logic [7:0]    byte_count_reg, byte_count_next;
    logic [7:0]    timeout_count_reg, timeout_count_next;
    logic [FW-1:0] write_fill_reg, write_fill_next;
    logic [6:0]    held_dev_addr_reg, held_dev_addr_next;
    logic [7:0]    held_reg_addr_reg, held_reg_addr_next;
    logic          held_is_read_reg, held_is_read_next;
    logic [7:0]    held_length_reg, held_length_next;
    logic          scl_level_reg, scl_level_next;
    logic          sda_level_reg, sda_level_next;
    logic          err_flag_reg, err_flag_next;

    logic [7:0]    mem [BUF_DEPTH];
    logic [7:0]    prefetch_reg;
    logic [7:0]    pf_sum;
    logic [AW-1:0] pf_addr;
    logic          mem_we;

    logic [7:0]    hold;
    logic          rx_last;
    logic          go;
    logic          rd_v;
    logic          rd_l;
    logic          done;
    logic [1:0]    status;

    assign hold    = (phase_ticks_reg != 8'd0) ? phase_ticks_reg : 8'd1;
    assign rx_last = ({1'b0, byte_count_reg} + 9'd1) >= {1'b0, held_length_reg};

    // the next data byte is prefetched from the queue into a register ahead of the ack that sends it
    assign pf_sum  = byte_count_reg + 8'd1;
    assign pf_addr = (role_reg == R_DATA) ? pf_sum[AW-1:0] : '0;
    assign mem_we  = in_fire && (item.action == ACT_QUEUE) && (state_reg == S_IDLE)
                     && (write_fill_reg < FW'(BUF_DEPTH));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[write_fill_reg[AW-1:0]] <= item.wr_data;
        end
        prefetch_reg <= mem[pf_addr];
    end

    always_comb
    begin
        state_next         = state_reg;
        role_next          = role_reg;
        phase_ticks_next   = phase_ticks_reg;
        ack_timeout_next   = ack_timeout_reg;
        phase_count_next   = phase_count_reg;
        bit_count_next     = bit_count_reg;
        shift_reg_next     = shift_reg_reg;
        byte_count_next    = byte_count_reg;
        timeout_count_next = timeout_count_reg;
        write_fill_next    = write_fill_reg;
        held_dev_addr_next = held_dev_addr_reg;
        held_reg_addr_next = held_reg_addr_reg;
        held_is_read_next  = held_is_read_reg;
        held_length_next   = held_length_reg;
        scl_level_next     = scl_level_reg;
        sda_level_next     = sda_level_reg;
        err_flag_next      = err_flag_reg;
        go                 = 1'b0;
        go_st              = S_IDLE;
        rd_v               = 1'b0;
        rd_l               = 1'b0;
        done               = 1'b0;
        status             = STS_OK;

        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PHASE_TICKS: phase_ticks_next = cfg_wdata;
                REG_ACK_TIMEOUT: ack_timeout_next = cfg_wdata;
                default: ;
            endcase
        end

        if (in_fire)
        begin
            unique case (item.action)
                ACT_QUEUE:
                begin
                    if (mem_we)
                    begin
                        write_fill_next = write_fill_reg + FW'(1);
                    end
                end
                ACT_START:
                begin
                    if (state_reg == S_IDLE)
                    begin
                        held_dev_addr_next = item.dev_addr;
                        held_reg_addr_next = item.reg_addr;
                        held_is_read_next  = item.is_read;
                        held_length_next   = item.length;
                        if (!item.is_read && (CW'(item.length) > CW'(write_fill_reg)))
                        begin
                            done   = 1'b1;
                            status = STS_OVERLEN;
                        end
                        else
                        begin
                            role_next          = R_ADDR_WR;
                            err_flag_next      = 1'b0;
                            byte_count_next    = 8'd0;
                            bit_count_next     = 4'd0;
                            timeout_count_next = 8'd0;
                            go                 = 1'b1;
                            go_st              = S_ST_SDA_HI;
                        end
                    end
                end
                ACT_TICK:
                begin
                    if (state_reg != S_IDLE)
                    begin
                        if (phase_count_reg > 8'd1)
                        begin
                            phase_count_next = phase_count_reg - 8'd1;
                        end
                        else
                        begin
                            go = 1'b1;
                            case (state_reg)
                                S_ST_SDA_HI: go_st = S_ST_SCL_HI;
                                S_ST_SCL_HI: go_st = S_ST_SDA_LO;
                                S_ST_SDA_LO: go_st = S_ST_SCL_LO;
                                S_ST_SCL_LO:
                                begin
                                    shift_reg_next = {held_dev_addr_reg,
                                                      role_reg == R_ADDR_RD};
                                    bit_count_next = 4'd0;
                                    go_st          = S_TX_SCL_LO;
                                end
                                S_TX_SCL_LO: go_st = S_TX_SDA;
                                S_TX_SDA:    go_st = S_TX_SCL_HI;
                                S_TX_SCL_HI:
                                begin
                                    shift_reg_next = {shift_reg_reg[6:0], 1'b0};
                                    bit_count_next = bit_count_reg + 4'd1;
                                    go_st = (bit_count_next >= 4'd8) ? S_TX_END : S_TX_SCL_LO;
                                end
                                S_TX_END: go_st = S_ACK_REL;
                                S_ACK_REL:
                                begin
                                    timeout_count_next = 8'd0;
                                    go_st              = S_ACK_SCL_HI;
                                end
                                S_ACK_SCL_HI:
                                begin
                                    if ((role_reg == R_ADDR_WR || role_reg == R_ADDR_RD)
                                        && item.sda_in)
                                    begin
                                        timeout_count_next = timeout_count_reg + 8'd1;
                                        if (timeout_count_next >= ack_timeout_reg)
                                        begin
                                            err_flag_next = 1'b1;
                                            go_st         = S_SP_SCL_LO;
                                        end
                                        else
                                        begin
                                            go               = 1'b0;
                                            phase_count_next = hold;
                                        end
                                    end
                                    else
                                    begin
                                        go_st = S_ACK_SCL_LO;
                                    end
                                end
                                S_ACK_SCL_LO:
                                begin
                                    case (role_reg)
                                        R_ADDR_WR:
                                        begin
                                            role_next      = R_REG;
                                            shift_reg_next = held_reg_addr_reg;
                                            bit_count_next = 4'd0;
                                            go_st          = S_TX_SCL_LO;
                                        end
                                        R_REG:
                                        begin
                                            if (held_length_reg == 8'd0)
                                            begin
                                                go_st = S_SP_SCL_LO;
                                            end
                                            else if (held_is_read_reg)
                                            begin
                                                role_next = R_ADDR_RD;
                                                go_st     = S_ST_SDA_HI;
                                            end
                                            else
                                            begin
                                                byte_count_next = 8'd0;
                                                role_next       = R_DATA;
                                                shift_reg_next  = prefetch_reg;
                                                bit_count_next  = 4'd0;
                                                go_st           = S_TX_SCL_LO;
                                            end
                                        end
                                        R_DATA:
                                        begin
                                            byte_count_next = byte_count_reg + 8'd1;
                                            if (byte_count_next < held_length_reg)
                                            begin
                                                shift_reg_next = prefetch_reg;
                                                bit_count_next = 4'd0;
                                                go_st          = S_TX_SCL_LO;
                                            end
                                            else
                                            begin
                                                go_st = S_SP_SCL_LO;
                                            end
                                        end
                                        default:
                                        begin
                                            byte_count_next = 8'd0;
                                            bit_count_next  = 4'd0;
                                            shift_reg_next  = 8'd0;
                                            go_st           = S_RX_SCL_LO;
                                        end
                                    endcase
                                end
                                S_RX_SCL_LO: go_st = S_RX_SCL_HI;
                                S_RX_SCL_HI:
                                begin
                                    shift_reg_next = {shift_reg_reg[6:0], item.sda_in};
                                    bit_count_next = bit_count_reg + 4'd1;
                                    if (bit_count_next >= 4'd8)
                                    begin
                                        rd_v  = 1'b1;
                                        rd_l  = rx_last;
                                        go_st = S_RX_END;
                                    end
                                    else
                                    begin
                                        go_st = S_RX_SCL_LO;
                                    end
                                end
                                S_RX_END:    go_st = S_MA_SDA;
                                S_MA_SDA:    go_st = S_MA_SCL_HI;
                                S_MA_SCL_HI: go_st = S_MA_SCL_LO;
                                S_MA_SCL_LO:
                                begin
                                    byte_count_next = byte_count_reg + 8'd1;
                                    if (byte_count_next < held_length_reg)
                                    begin
                                        bit_count_next = 4'd0;
                                        shift_reg_next = 8'd0;
                                        go_st          = S_RX_SCL_LO;
                                    end
                                    else
                                    begin
                                        go_st = S_SP_SCL_LO;
                                    end
                                end
                                S_SP_SCL_LO: go_st = S_SP_SDA_LO;
                                S_SP_SDA_LO: go_st = S_SP_SCL_HI;
                                S_SP_SCL_HI: go_st = S_SP_SDA_HI;
                                default:
                                begin
                                    // end of stop: back to idle, queue emptied
                                    go               = 1'b0;
                                    state_next       = S_IDLE;
                                    phase_count_next = 8'd0;
                                    write_fill_next  = '0;
                                    done             = 1'b1;
                                end
                            endcase
                            if (done)
                            begin
                                status = err_flag_next ? STS_NACK : STS_OK;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        // pin levels set on entry to each step
        if (go)
        begin
            state_next       = go_st;
            phase_count_next = hold;
            case (go_st)
                S_ST_SDA_HI, S_ACK_REL, S_SP_SDA_HI: sda_level_next = 1'b1;
                S_ST_SCL_HI, S_TX_SCL_HI, S_ACK_SCL_HI,
                S_RX_SCL_HI, S_MA_SCL_HI, S_SP_SCL_HI: scl_level_next = 1'b1;
                S_ST_SDA_LO, S_SP_SDA_LO: sda_level_next = 1'b0;
                S_TX_SDA: sda_level_next = shift_reg_next[7];
                S_RX_SCL_LO:
                begin
                    scl_level_next = 1'b0;
                    sda_level_next = 1'b1;
                end
                S_MA_SDA: sda_level_next = rx_last;
                default: scl_level_next = 1'b0;
            endcase
        end

        res.scl_out  = scl_level_next;
        res.sda_out  = sda_level_next;
        res.busy_res = (state_next != S_IDLE);
        res.rd_data  = rd_v ? shift_reg_next : 8'd0;
        res.rd_valid = rd_v;
        res.rd_last  = rd_v && rd_l;
        res.done_res = done;
        res.status   = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            role_reg          <= R_ADDR_WR;
            phase_ticks_reg   <= 8'd1;
            ack_timeout_reg   <= 8'd5;
            phase_count_reg   <= 8'd0;
            bit_count_reg     <= 4'd0;
            shift_reg_reg     <= 8'd0;
            byte_count_reg    <= 8'd0;
            timeout_count_reg <= 8'd0;
            write_fill_reg    <= '0;
            held_dev_addr_reg <= 7'd0;
            held_reg_addr_reg <= 8'd0;
            held_is_read_reg  <= 1'b0;
            held_length_reg   <= 8'd0;
            scl_level_reg     <= 1'b1;
            sda_level_reg     <= 1'b1;
            err_flag_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            role_reg          <= role_next;
            phase_ticks_reg   <= phase_ticks_next;
            ack_timeout_reg   <= ack_timeout_next;
            phase_count_reg   <= phase_count_next;
            bit_count_reg     <= bit_count_next;
            shift_reg_reg     <= shift_reg_next;
            byte_count_reg    <= byte_count_next;
            timeout_count_reg <= timeout_count_next;
            write_fill_reg    <= write_fill_next;
            held_dev_addr_reg <= held_dev_addr_next;
            held_reg_addr_reg <= held_reg_addr_next;
            held_is_read_reg  <= held_is_read_next;
            held_length_reg   <= held_length_next;
            scl_level_reg     <= scl_level_next;
            sda_level_reg     <= sda_level_next;
            err_flag_reg      <= err_flag_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> phase_count_reg != 8'd0)
        else $error("phase counter empty while busy");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        write_fill_reg <= FW'(BUF_DEPTH))
        else $error("write queue overfilled");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && res.done_res |=> state_reg == S_IDLE)
        else $error("done without returning to idle");
`endif

endmodule

FILE: rtl/i2cmra_obuf.sv
module i2cmra_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cmra_pkg::result_t in_res,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cmra_pkg::result_t out_res
);
    import i2cmra_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_res_reg;
    result_t skid_res_reg;
    logic    load_out;
    logic    load_skid;
    logic    pop_skid;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign pop_skid  = skid_valid_reg && out_ready;
    assign load_out  = !skid_valid_reg && in_valid && (!out_valid_reg || out_ready);
    assign load_skid = !skid_valid_reg && in_valid && out_valid_reg && !out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop_skid)
        begin
            skid_valid_next = 1'b0;
        end
        else if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (load_skid)
        begin
            skid_valid_next = 1'b1;
        end
        else if (!skid_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_skid)
        begin
            out_res_reg <= skid_res_reg;
        end
        else if (load_out)
        begin
            out_res_reg <= in_res;
        end
        if (load_skid)
        begin
            skid_res_reg <= in_res;
        end
    end

endmodule

FILE: rtl/i2c_master_register_access_unit.sv
// A result beat is registered in the output stage before it leaves on m_axis.
// Throughput: a beat per cycle unless stalled; each is one full controller step.
// A two-entry output stage keeps input open for one beat while m_axis stalls.
// Reset (rst_n low, async): controller idle, SCL/SDA released, write queue empty,
// phase_ticks = 1, ack_timeout = 5, output stage empty.
module i2c_master_register_access_unit #(
    parameter int BUF_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dev_addr[6:0], reg_addr[14:7], is_read[15], length[23:16],
    // wr_data[31:24], sda_in[32], zero[39:33]
    input  logic [39:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_out[0], sda_out[1], busy_res[2], rd_data[10:3], rd_valid[11],
    // done_res[12], status[14:13], zero[15]
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import i2cmra_pkg::*;

    item_t   item;
    result_t res;
    result_t out_res;
    logic    in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    assign item.action   = s_axis_tuser;
    assign item.dev_addr = s_axis_tdata[6:0];
    assign item.reg_addr = s_axis_tdata[14:7];
    assign item.is_read  = s_axis_tdata[15];
    assign item.length   = s_axis_tdata[23:16];
    assign item.wr_data  = s_axis_tdata[31:24];
    assign item.sda_in   = s_axis_tdata[32];

    i2cmra_ctrl #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .res       (res)
    );

    i2cmra_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_res    (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.status, out_res.done_res, out_res.rd_valid,
                           out_res.rd_data, out_res.busy_res, out_res.sda_out,
                           out_res.scl_out};
    assign m_axis_tlast = out_res.rd_last;

endmodule
